// File: sv/spz_pkg.sv
// Shared constants for the Spritz-style sponge hash unit.
package spz_pkg;

   // Byte and permutation geometry
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned FUNC_W    = 2;
   localparam int unsigned NIBBLE_W  = 4;
   localparam int unsigned PERM_SIZE = 256;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_INIT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_ABSORB = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_DRIP   = 2'd2;

   // Absorb position at which a shuffle is forced; nibble swaps land at or above it
   localparam logic [BYTE_W-1:0] ABSORB_LIMIT = 8'd240;
   localparam logic [BYTE_W-1:0] LAST_INDEX   = 8'd255;
   localparam logic [BYTE_W-1:0] STRIDE_RESET = 8'd1;
   localparam logic [BYTE_W-1:0] STRIDE_STEP  = 8'd2;

endpackage

// File: sv/spritz_like_sponge_hash_unit.sv
// Spritz-style sponge hash unit: sequencer around a 256-byte permutation memory.
//
// The permutation lives in one 256 x 8 memory with a registered read port and one
// write port, and a sequencer does every read-modify-write through it, one item at
// a time. After reset, and after each init beat, a clearing pass writes the identity
// permutation; no request beat is taken during it. One state update is three
// dependent reads and then two writes, and a shuffle is 256 updates. An absorb beat
// swaps its two nibbles into the permutation, plus a shuffle whenever the absorb
// position reaches 240 (once per 120 bytes). A drip beat runs one state update, after
// a shuffle when bytes were absorbed since the last one. The drip result sits in an
// output register, so the next request beat can be taken while it waits.
module spritz_like_sponge_hash_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [spz_pkg::FUNC_W-1:0]  req_func,
   input  logic [spz_pkg::BYTE_W-1:0]  req_data_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [spz_pkg::BYTE_W-1:0]  rsp_out_byte
);

   localparam int unsigned ST_W = 4;
   localparam logic [ST_W-1:0] ST_CLEAR = 4'd0;
   localparam logic [ST_W-1:0] ST_IDLE  = 4'd1;
   localparam logic [ST_W-1:0] ST_NIB   = 4'd2;
   localparam logic [ST_W-1:0] ST_SW_A  = 4'd3;
   localparam logic [ST_W-1:0] ST_SW_B  = 4'd4;
   localparam logic [ST_W-1:0] ST_SW_C  = 4'd5;
   localparam logic [ST_W-1:0] ST_SW_D  = 4'd6;
   localparam logic [ST_W-1:0] ST_U_A   = 4'd7;
   localparam logic [ST_W-1:0] ST_U_B   = 4'd8;
   localparam logic [ST_W-1:0] ST_U_C   = 4'd9;
   localparam logic [ST_W-1:0] ST_U_D   = 4'd10;
   localparam logic [ST_W-1:0] ST_U_E   = 4'd11;
   localparam logic [ST_W-1:0] ST_OUT   = 4'd12;

   localparam int unsigned BW = spz_pkg::BYTE_W;

   // Sequencer and state registers
   logic [ST_W-1:0]               state_ff, state_in;
   logic [BW-1:0]                 pos_ff, pos_in;
   logic [BW-1:0]                 i_ff, i_in;
   logic [BW-1:0]                 j_ff, j_in;
   logic [BW-1:0]                 stride_ff, stride_in;
   logic [BW-1:0]                 cnt_ff, cnt_in;
   logic                          shuf_ff, shuf_in;
   logic                          half_ff, half_in;
   logic [spz_pkg::FUNC_W-1:0]    func_ff, func_in;
   logic [BW-1:0]                 data_ff, data_in;
   logic [BW-1:0]                 held_ff, held_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]                 rsp_data_ff, rsp_data_in;

   // Permutation memory ports
   logic [BW-1:0]                 perm_mem [spz_pkg::PERM_SIZE];
   logic [BW-1:0]                 mem_rdata_ff;
   logic [BW-1:0]                 mem_raddr;
   logic [BW-1:0]                 mem_waddr;
   logic [BW-1:0]                 mem_wdata;
   logic                          mem_we;

   logic [spz_pkg::NIBBLE_W-1:0]  nibble;
   logic [BW-1:0]                 swap_hi_addr;
   logic                          rsp_free;
   logic                          req_take;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_take     = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_data_ff;
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;

   // Nibble under work and its swap partner at or above the absorb limit
   assign nibble       = half_ff ? data_ff[BW-1:spz_pkg::NIBBLE_W]
                                 : data_ff[spz_pkg::NIBBLE_W-1:0];
   assign swap_hi_addr = spz_pkg::ABSORB_LIMIT | {{(BW-spz_pkg::NIBBLE_W){1'b0}}, nibble};

   // Permutation memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         perm_mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= perm_mem[mem_raddr];
   end

   // Sequencer next state and memory access
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      stride_in    = stride_ff;
      cnt_in       = cnt_ff;
      shuf_in      = shuf_ff;
      half_in      = half_ff;
      func_in      = func_ff;
      data_in      = data_ff;
      held_in      = held_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mem_raddr    = i_ff;
      mem_waddr    = cnt_ff;
      mem_wdata    = cnt_ff;
      mem_we       = 1'b0;

      unique case (state_ff)
         // identity fill, one entry a cycle
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff;
            mem_wdata = cnt_ff;
            cnt_in    = cnt_ff + 8'd1;
            if (cnt_ff == spz_pkg::LAST_INDEX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_take) begin
               func_in = req_func;
               data_in = req_data_byte;
               half_in = 1'b0;
               cnt_in  = '0;
               case (req_func)
                  spz_pkg::FUNC_INIT: begin
                     pos_in    = '0;
                     i_in      = '0;
                     j_in      = '0;
                     stride_in = spz_pkg::STRIDE_RESET;
                     state_in  = ST_CLEAR;
                  end
                  spz_pkg::FUNC_ABSORB: begin
                     state_in = ST_NIB;
                  end
                  spz_pkg::FUNC_DRIP: begin
                     shuf_in  = (pos_ff != '0);
                     state_in = ST_U_A;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // forced shuffle when the absorb position is full
         ST_NIB: begin
            if (pos_ff == spz_pkg::ABSORB_LIMIT) begin
               shuf_in  = 1'b1;
               cnt_in   = '0;
               state_in = ST_U_A;
            end else begin
               state_in = ST_SW_A;
            end
         end

         // nibble swap of perm[pos] and perm[240 + nibble]
         ST_SW_A: begin
            mem_raddr = pos_ff;
            state_in  = ST_SW_B;
         end
         ST_SW_B: begin
            held_in   = mem_rdata_ff;
            mem_raddr = swap_hi_addr;
            state_in  = ST_SW_C;
         end
         ST_SW_C: begin
            mem_we    = 1'b1;
            mem_waddr = pos_ff;
            mem_wdata = mem_rdata_ff;
            state_in  = ST_SW_D;
         end
         ST_SW_D: begin
            mem_we    = 1'b1;
            mem_waddr = swap_hi_addr;
            mem_wdata = held_ff;
            pos_in    = pos_ff + 8'd1;
            if (!half_ff) begin
               half_in  = 1'b1;
               state_in = ST_NIB;
            end else begin
               state_in = ST_IDLE;
            end
         end

         // update: i += stride, read perm[i]
         ST_U_A: begin
            i_in      = i_ff + stride_ff;
            mem_raddr = i_ff + stride_ff;
            state_in  = ST_U_B;
         end
         // read perm[j + perm[i]]
         ST_U_B: begin
            held_in   = mem_rdata_ff;
            mem_raddr = j_ff + mem_rdata_ff;
            state_in  = ST_U_C;
         end
         // new j, read perm[j]
         ST_U_C: begin
            j_in      = mem_rdata_ff;
            mem_raddr = mem_rdata_ff;
            state_in  = ST_U_D;
         end
         ST_U_D: begin
            mem_we    = 1'b1;
            mem_waddr = i_ff;
            mem_wdata = mem_rdata_ff;
            state_in  = ST_U_E;
         end
         // second half of the swap; perm[j] ends as the old perm[i]
         ST_U_E: begin
            mem_we    = 1'b1;
            mem_waddr = j_ff;
            mem_wdata = held_ff;
            if (shuf_ff) begin
               cnt_in = cnt_ff + 8'd1;
               if (cnt_ff == spz_pkg::LAST_INDEX) begin
                  shuf_in   = 1'b0;
                  stride_in = stride_ff + spz_pkg::STRIDE_STEP;
                  pos_in    = '0;
                  state_in  = (func_ff == spz_pkg::FUNC_DRIP) ? ST_U_A : ST_NIB;
               end else begin
                  state_in = ST_U_A;
               end
            end else begin
               state_in = ST_OUT;
            end
         end

         // hand the dripped byte to the output register
         ST_OUT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = held_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         pos_ff       <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         stride_ff    <= spz_pkg::STRIDE_RESET;
         cnt_ff       <= '0;
         shuf_ff      <= 1'b0;
         half_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         stride_ff    <= stride_in;
         cnt_ff       <= cnt_in;
         shuf_ff      <= shuf_in;
         half_ff      <= half_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      data_ff     <= data_in;
      held_ff     <= held_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Absorb position never runs past the forced-shuffle point
   assert property (@(posedge clock) disable iff (reset)
      pos_ff <= spz_pkg::ABSORB_LIMIT)
      else $error("absorb position beyond limit");

   // Stride starts at one and grows by two, so it stays odd
   assert property (@(posedge clock) disable iff (reset)
      stride_ff[0])
      else $error("stride became even");

   // A new result only comes out of the output step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("result raised outside output step");

   // A waiting result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("pending result lost");

endmodule

// File: tb/tb_spritz_like_sponge_hash_unit.sv
// Testbench for the sponge hash unit: directed beats and random init/absorb/drip traffic checked by a local predictor.
`timescale 1ns / 1ps

typedef bit [spz_pkg::BYTE_W-1:0] octet_type;

// Tracks the permutation state and holds the drip bytes still owed by the block
class drip_scoreboard;
   octet_type sbox [spz_pkg::PERM_SIZE];
   octet_type fill_pos;
   octet_type ptr_i;
   octet_type ptr_j;
   octet_type step_sz;
   octet_type owed_drips [$];
   int        mismatches;

   function new();
      mismatches = 0;
      clear_state();
   endfunction

   function void clear_state();
      for (int k = 0; k < spz_pkg::PERM_SIZE; k++) begin
         sbox[k] = octet_type'(k);
      end
      fill_pos = '0;
      ptr_i    = '0;
      ptr_j    = '0;
      step_sz  = spz_pkg::STRIDE_RESET;
   endfunction

   function void swap_cells(octet_type p, octet_type q);
      octet_type t;
      t       = sbox[p];
      sbox[p] = sbox[q];
      sbox[q] = t;
   endfunction

   // one state update; all index math wraps at 256
   function void permute_step();
      octet_type k;
      ptr_i = ptr_i + step_sz;
      k     = ptr_j + sbox[ptr_i];
      ptr_j = sbox[k];
      swap_cells(ptr_i, ptr_j);
   endfunction

   function void full_mix();
      for (int n = 0; n < spz_pkg::PERM_SIZE; n++) begin
         permute_step();
      end
      step_sz  = step_sz + spz_pkg::STRIDE_STEP;
      fill_pos = '0;
   endfunction

   function void mix_nibble(bit [spz_pkg::NIBBLE_W-1:0] x);
      if (fill_pos == spz_pkg::ABSORB_LIMIT) begin
         full_mix();
      end
      swap_cells(fill_pos, spz_pkg::ABSORB_LIMIT + octet_type'(x));
      fill_pos = fill_pos + 8'd1;
   endfunction

   // accepted request beat
   function void note_request(logic [spz_pkg::FUNC_W-1:0] f, logic [spz_pkg::BYTE_W-1:0] d);
      case (f)
         spz_pkg::FUNC_INIT: begin
            clear_state();
         end
         spz_pkg::FUNC_ABSORB: begin
            mix_nibble(d[3:0]);
            mix_nibble(d[7:4]);
         end
         spz_pkg::FUNC_DRIP: begin
            if (fill_pos != 8'd0) begin
               full_mix();
            end
            permute_step();
            owed_drips.push_back(sbox[ptr_j]);
         end
         default: begin
            // spare code: no state change, no result
         end
      endcase
   endfunction

   // accepted response beat
   function void check_drip(logic [spz_pkg::BYTE_W-1:0] actual);
      octet_type want;
      if (owed_drips.size() == 0) begin
         $display("%0t: unexpected drip byte, expected none, got %02h", $time, actual);
         mismatches++;
      end else begin
         want = owed_drips.pop_front();
         if (actual !== want) begin
            $display("%0t: out_byte mismatch, expected %02h, got %02h", $time, want, actual);
            mismatches++;
         end
      end
   endfunction

   function int pending();
      return owed_drips.size();
   endfunction
endclass

module tb_spritz_like_sponge_hash_unit;

   localparam logic [spz_pkg::FUNC_W-1:0] FUNC_SPARE   = 2'd3;
   localparam int                         RANDOM_BEATS = 950;
   localparam int                         DRAIN_CYCLES = 1400;
   localparam longint                     CYCLE_LIMIT  = 10000000;

   logic                         clock;
   logic                         reset         = 1'b1;
   logic                         req_valid     = 1'b0;
   logic                         req_stall;
   logic [spz_pkg::FUNC_W-1:0]   req_func      = spz_pkg::FUNC_INIT;
   logic [spz_pkg::BYTE_W-1:0]   req_data_byte = '0;
   logic                         rsp_valid;
   logic                         rsp_stall     = 1'b0;
   logic [spz_pkg::BYTE_W-1:0]   rsp_out_byte;

   drip_scoreboard sb;
   int     send_idle_pct = 0;
   int     rsp_stall_pct = 0;
   int     beats_sent    = 0;
   longint cycle_count   = 0;

   spritz_like_sponge_hash_unit uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_func      (req_func),
      .req_data_byte (req_data_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // beat monitor: values seen here are the ones sampled at this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_request(req_func, req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            sb.check_drip(rsp_out_byte);
         end
      end
   end

   // drive one request beat and hold it until taken
   task automatic send_item(input logic [spz_pkg::FUNC_W-1:0] f,
                            input logic [spz_pkg::BYTE_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_func      <= f;
      req_data_byte <= d;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (f != FUNC_SPARE) begin
         beats_sent++;
      end
   endtask

   // occasional spare-code beat mixed into traffic
   task automatic maybe_noise();
      if ($urandom_range(24) == 0) begin
         send_item(FUNC_SPARE, octet_type'($urandom));
      end
   endtask

   // one message: optional init, absorbed bytes, then a run of drips
   task automatic send_message(input bit allow_init, input bit long_msg);
      int n_abs;
      int n_drip;
      if (allow_init && $urandom_range(9) == 0) begin
         send_item(spz_pkg::FUNC_INIT, octet_type'($urandom));
      end
      if (long_msg) begin
         n_abs = $urandom_range(120, 130);
      end else if ($urandom_range(19) == 0) begin
         n_abs = 0;
      end else begin
         n_abs = $urandom_range(1, 3);
      end
      repeat (n_abs) begin
         maybe_noise();
         send_item(spz_pkg::FUNC_ABSORB, octet_type'($urandom));
      end
      n_drip = $urandom_range(1, 3);
      repeat (n_drip) begin
         maybe_noise();
         send_item(spz_pkg::FUNC_DRIP, octet_type'($urandom));
      end
   endtask

   initial begin
      sb = new();
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: fresh drip, extreme bytes, spare code, init in mid-stream
      send_item(spz_pkg::FUNC_DRIP,   8'h00);
      send_item(spz_pkg::FUNC_ABSORB, 8'h00);
      send_item(spz_pkg::FUNC_ABSORB, 8'hFF);
      send_item(spz_pkg::FUNC_ABSORB, 8'h0F);
      send_item(spz_pkg::FUNC_ABSORB, 8'hF0);
      send_item(spz_pkg::FUNC_DRIP,   8'hFF);
      send_item(spz_pkg::FUNC_DRIP,   8'h00);
      send_item(FUNC_SPARE,           8'hFF);
      send_item(spz_pkg::FUNC_ABSORB, 8'hA5);
      send_item(FUNC_SPARE,           8'h00);
      send_item(spz_pkg::FUNC_DRIP,   8'h55);
      send_item(spz_pkg::FUNC_INIT,   8'h00);
      send_item(spz_pkg::FUNC_DRIP,   8'hAA);
      send_item(spz_pkg::FUNC_INIT,   8'hFF);
      send_item(spz_pkg::FUNC_ABSORB, 8'h5A);
      send_item(spz_pkg::FUNC_INIT,   8'h00);
      send_item(spz_pkg::FUNC_ABSORB, 8'h3C);
      send_item(spz_pkg::FUNC_DRIP,   8'h00);
      send_item(spz_pkg::FUNC_DRIP,   8'hC3);
      beats_sent = 0;

      // random phases; no init before the last so the stride gets to wrap
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 54; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 54; end
            default: begin send_idle_pct = 30; rsp_stall_pct = 30; end
         endcase
         if (ph == 1 || ph == 3) begin
            send_message(ph == 3, 1'b1);
         end
         while (beats_sent < RANDOM_BEATS * (ph + 1) / 4) begin
            send_message(ph == 3, 1'b0);
         end
      end
      req_valid <= 1'b0;

      // drain, then cover any absorb shuffle still running
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
